[hdl/sm3_pkg.sv]
// SM3 engine shared constants, command and status types, and round functions.
package sm3_pkg;

    localparam int WORD_W  = 32;
    localparam int BLOCK_N = 16;
    localparam int CHAIN_N = 8;

    localparam logic [WORD_W-1:0] IV [CHAIN_N] = '{
        32'h7380_166F, 32'h4914_B2B9, 32'h1724_42D7, 32'hDA8A_0600,
        32'hA96F_30BC, 32'h1631_38AA, 32'hE38D_EE4D, 32'hB0FB_0E4E
    };

    localparam logic [WORD_W-1:0] T_EARLY = 32'h79CC_4519;
    localparam logic [WORD_W-1:0] T_LATE  = 32'h7A87_9D8A;
    localparam logic [7:0]        PAD_BYTE = 8'h80;

    // sources for a word shifted into the block window
    localparam logic [2:0] SRC_IN   = 3'd0;  // message word as given
    localparam logic [2:0] SRC_PADW = 3'd1;  // partial last word, masked and padded
    localparam logic [2:0] SRC_P80  = 3'd2;  // padding byte opening a fresh word
    localparam logic [2:0] SRC_ZERO = 3'd3;
    localparam logic [2:0] SRC_LHI  = 3'd4;  // bit length, upper half
    localparam logic [2:0] SRC_LLO  = 3'd5;  // bit length, lower half

    typedef struct packed {
        logic       acc;       // input word taken: update bit length
        logic       shift_en;  // push one word into the window
        logic [2:0] src;
        logic       start;     // load working variables from the chain value
        logic       round;     // one compression round
        logic       t_switch;  // round 15: next constant is the late one
        logic       late;      // rounds 16..63: majority / choose functions
        logic       fin;       // fold working variables into the chain value
        logic       digest;    // copy chain value out, restart the message
    } t_dp_cmd;

    typedef struct packed {
        logic obuf_busy;
    } t_dp_sts;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] p0(input logic [WORD_W-1:0] x);
        return x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic logic [WORD_W-1:0] p1(input logic [WORD_W-1:0] x);
        return x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

endpackage

[hdl/sm3_if.sv]
// Valid/ready channel interfaces for message words in and digest words out.
interface sm3_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic [2:0]  word_bytes;
    logic        last_word;

    modport source (output valid, output msg_word, output word_bytes, output last_word,
                    input ready);
    modport sink   (input valid, input msg_word, input word_bytes, input last_word,
                    output ready);
endinterface

interface sm3_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;

    modport source (output valid, output digest_word, output digest_index,
                    output digest_last, input ready);
    modport sink   (input valid, input digest_word, input digest_index,
                    input digest_last, output ready);
endinterface

[hdl/sm3_hash_engine.sv]
// SM3 hash engine top level: controller and datapath behind valid/ready channels.
// Each 16-word block: one word taken per cycle while the input is ready, then 64 rounds and a fold.
// Sustained rate is set by the single round unit; no words are taken while a block compresses.
// Pad words are shifted in one per cycle; the digest buffer loads in S_DIG after the last fold,
// waiting while the previous digest drains, and offers one word per handshake from then on.
// Reset (synchronous, active low) restores the IV and clears counts; no clearing pass.
module sm3_hash_engine (
    input  logic   i_clk,
    input  logic   i_rst_n,
    sm3_in_if.sink    i_msg,
    sm3_out_if.source o_digest
);

    sm3_pkg::t_dp_cmd cmd;
    sm3_pkg::t_dp_sts sts;

    // controller sees the handshake, the two fields that steer padding, and the datapath status
    sm3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_msg.valid),
        .i_in_bytes (i_msg.word_bytes),
        .i_in_last  (i_msg.last_word),
        .o_in_ready (i_msg.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath owns the block window, round unit, chain value and digest buffer
    sm3_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_msg_word   (i_msg.msg_word),
        .i_word_bytes (i_msg.word_bytes),
        .i_last_word  (i_msg.last_word),
        .o_dig_valid  (o_digest.valid),
        .i_dig_ready  (o_digest.ready),
        .o_dig_word   (o_digest.digest_word),
        .o_dig_index  (o_digest.digest_index),
        .o_dig_last   (o_digest.digest_last)
    );

endmodule

[hdl/sm3_ctrl.sv]
// SM3 controller: word gathering, padding sequence, round count, digest hand-off.
module sm3_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [2:0]       i_in_bytes,
    input  logic             i_in_last,
    output logic             o_in_ready,
    input  sm3_pkg::t_dp_sts i_sts,
    output sm3_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IN  = 3'd0;
    localparam logic [2:0] S_RND = 3'd1;
    localparam logic [2:0] S_FIN = 3'd2;
    localparam logic [2:0] S_PAD = 3'd3;
    localparam logic [2:0] S_DIG = 3'd4;

    logic [2:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [5:0] r_j, n_j;
    logic       r_pad, n_pad;
    logic       r_need80, n_need80;
    logic       r_hi_done, n_hi_done;
    logic       r_done, n_done;

    assign o_in_ready = (r_state == S_IN);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_j       = r_j;
        n_pad     = r_pad;
        n_need80  = r_need80;
        n_hi_done = r_hi_done;
        n_done    = r_done;
        o_cmd     = '0;
        o_cmd.src = sm3_pkg::SRC_IN;
        unique case (r_state)
            S_IN: begin
                if (i_in_valid) begin
                    o_cmd.acc      = 1'b1;
                    o_cmd.shift_en = 1'b1;
                    if (i_in_last) begin
                        n_pad = 1'b1;
                        // four or more bytes: word goes whole, padding opens the next
                        if (i_in_bytes[2]) begin
                            n_need80 = 1'b1;
                        end else begin
                            o_cmd.src = sm3_pkg::SRC_PADW;
                        end
                    end
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        o_cmd.start = 1'b1;
                        n_j         = '0;
                        n_state     = S_RND;
                    end else if (i_in_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_RND: begin
                o_cmd.round    = 1'b1;
                o_cmd.t_switch = (r_j == 6'd15);
                o_cmd.late     = r_j[5] | r_j[4];
                n_j            = r_j + 6'd1;
                if (r_j == 6'd63) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                priority if (r_done) n_state = S_DIG;
                else if (r_pad)      n_state = S_PAD;
                else                 n_state = S_IN;
            end
            S_PAD: begin
                o_cmd.shift_en = 1'b1;
                priority if (r_need80) begin
                    o_cmd.src = sm3_pkg::SRC_P80;
                    n_need80  = 1'b0;
                end else if (r_hi_done) begin
                    o_cmd.src = sm3_pkg::SRC_LLO;
                    n_done    = 1'b1;
                end else if (r_cnt == 4'd14) begin
                    o_cmd.src = sm3_pkg::SRC_LHI;
                    n_hi_done = 1'b1;
                end else begin
                    o_cmd.src = sm3_pkg::SRC_ZERO;
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    o_cmd.start = 1'b1;
                    n_j         = '0;
                    n_state     = S_RND;
                end
            end
            S_DIG: begin
                if (!i_sts.obuf_busy) begin
                    o_cmd.digest = 1'b1;
                    n_pad        = 1'b0;
                    n_need80     = 1'b0;
                    n_hi_done    = 1'b0;
                    n_done       = 1'b0;
                    n_state      = S_IN;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IN;
            r_cnt     <= '0;
            r_j       <= '0;
            r_pad     <= 1'b0;
            r_need80  <= 1'b0;
            r_hi_done <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_j       <= n_j;
            r_pad     <= n_pad;
            r_need80  <= n_need80;
            r_hi_done <= n_hi_done;
            r_done    <= n_done;
        end
    end

    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RND && r_j == 6'd63) |=> (r_state == S_FIN))
        else $error("compression did not finish after round 63");

    a_block_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.shift_en && r_cnt == 4'd15) |=> (r_state == S_RND && r_j == 6'd0))
        else $error("full block did not start compression");

    a_digest_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.digest |-> (!i_sts.obuf_busy && r_done && r_cnt == 4'd0))
        else $error("digest issued over a busy buffer or mid-block");

    a_len_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_pad && r_hi_done && !r_need80))
        else $error("length words out of order");

endmodule

[hdl/sm3_dp.sv]
// SM3 datapath: block window with expansion, round unit, chain value, digest buffer.
module sm3_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sm3_pkg::t_dp_cmd i_cmd,
    output sm3_pkg::t_dp_sts o_sts,
    input  logic [31:0]      i_msg_word,
    input  logic [2:0]       i_word_bytes,
    input  logic             i_last_word,
    output logic             o_dig_valid,
    input  logic             i_dig_ready,
    output logic [31:0]      o_dig_word,
    output logic [2:0]       o_dig_index,
    output logic             o_dig_last
);

    localparam int W = sm3_pkg::WORD_W;

    logic [W-1:0] r_win   [sm3_pkg::BLOCK_N];
    logic [W-1:0] r_v     [sm3_pkg::CHAIN_N];
    logic [W-1:0] r_chain [sm3_pkg::CHAIN_N];
    logic [W-1:0] r_obuf  [sm3_pkg::CHAIN_N];
    logic [W-1:0] r_tj;
    logic [63:0]  r_bits;
    logic [2:0]   r_oidx;
    logic         r_ovalid;

    logic [W-1:0] padw, in_w, exp_w, push_w;
    logic [W-1:0] a12, ss1, ss2, fv, gv, tt1, tt2;
    logic [2:0]   nb;
    logic [5:0]   bits_inc;
    logic         out_hs;

    // partial last word: keep leading bytes, padding byte right after them
    always_comb begin
        unique case (i_word_bytes[1:0])
            2'd0: padw = {sm3_pkg::PAD_BYTE, 24'h0};
            2'd1: padw = {i_msg_word[31:24], sm3_pkg::PAD_BYTE, 16'h0};
            2'd2: padw = {i_msg_word[31:16], sm3_pkg::PAD_BYTE, 8'h0};
            2'd3: padw = {i_msg_word[31:8], sm3_pkg::PAD_BYTE};
            default: padw = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.src)
            sm3_pkg::SRC_IN:   in_w = i_msg_word;
            sm3_pkg::SRC_PADW: in_w = padw;
            sm3_pkg::SRC_P80:  in_w = {sm3_pkg::PAD_BYTE, 24'h0};
            sm3_pkg::SRC_ZERO: in_w = '0;
            sm3_pkg::SRC_LHI:  in_w = r_bits[63:32];
            sm3_pkg::SRC_LLO:  in_w = r_bits[31:0];
            default:           in_w = '0;
        endcase
    end

    assign nb       = i_word_bytes[2] ? 3'd4 : i_word_bytes;
    assign bits_inc = i_last_word ? {nb, 3'b000} : 6'd32;

    // next expanded word from the 16-word window (window[0] is W[j])
    assign exp_w  = sm3_pkg::p1(r_win[0] ^ r_win[7] ^ sm3_pkg::rotl(r_win[13], 15))
                  ^ sm3_pkg::rotl(r_win[3], 7) ^ r_win[10];
    assign push_w = i_cmd.round ? exp_w : in_w;

    // round function
    assign a12 = sm3_pkg::rotl(r_v[0], 12);
    assign ss1 = sm3_pkg::rotl(a12 + r_v[4] + r_tj, 7);
    assign ss2 = ss1 ^ a12;
    assign fv  = i_cmd.late ? ((r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]))
                            : (r_v[0] ^ r_v[1] ^ r_v[2]);
    assign gv  = i_cmd.late ? ((r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]))
                            : (r_v[4] ^ r_v[5] ^ r_v[6]);
    assign tt1 = fv + r_v[3] + ss2 + (r_win[0] ^ r_win[4]);
    assign tt2 = gv + r_v[7] + ss1 + r_win[0];

    assign out_hs = r_ovalid & i_dig_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_en || i_cmd.round) begin
            for (int k = 0; k < sm3_pkg::BLOCK_N - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[sm3_pkg::BLOCK_N-1] <= push_w;
        end
        if (i_cmd.start) begin
            r_v  <= r_chain;
            r_tj <= sm3_pkg::T_EARLY;
        end else if (i_cmd.round) begin
            r_v[0] <= tt1;
            r_v[1] <= r_v[0];
            r_v[2] <= sm3_pkg::rotl(r_v[1], 9);
            r_v[3] <= r_v[2];
            r_v[4] <= sm3_pkg::p0(tt2);
            r_v[5] <= r_v[4];
            r_v[6] <= sm3_pkg::rotl(r_v[5], 19);
            r_v[7] <= r_v[6];
            r_tj   <= i_cmd.t_switch ? sm3_pkg::rotl(sm3_pkg::T_LATE, 16)
                                     : sm3_pkg::rotl(r_tj, 1);
        end
        if (i_cmd.digest) begin
            r_obuf <= r_chain;
        end else if (out_hs) begin
            for (int k = 0; k < sm3_pkg::CHAIN_N - 1; k++) begin
                r_obuf[k] <= r_obuf[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain  <= sm3_pkg::IV;
            r_bits   <= '0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.digest) begin
                r_chain <= sm3_pkg::IV;
                r_bits  <= '0;
            end else begin
                if (i_cmd.fin) begin
                    for (int k = 0; k < sm3_pkg::CHAIN_N; k++) begin
                        r_chain[k] <= r_chain[k] ^ r_v[k];
                    end
                end
                if (i_cmd.acc) begin
                    r_bits <= r_bits + {58'd0, bits_inc};
                end
            end
            if (i_cmd.digest) begin
                r_ovalid <= 1'b1;
                r_oidx   <= '0;
            end else if (out_hs) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    r_ovalid <= 1'b0;
                end
            end
        end
    end

    assign o_sts.obuf_busy = r_ovalid;
    assign o_dig_valid     = r_ovalid;
    assign o_dig_word      = r_obuf[0];
    assign o_dig_index     = r_oidx;
    assign o_dig_last      = (r_oidx == 3'd7);

    a_digest_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.digest |=> (r_ovalid && r_oidx == 3'd0 && r_chain[0] == sm3_pkg::IV[0]
                          && r_bits == 64'd0))
        else $error("digest hand-off did not restart the message");

    a_const_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> (r_tj == sm3_pkg::T_EARLY))
        else $error("round constant not reloaded at block start");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_dig_ready) |=> (r_ovalid && $stable(r_oidx) && $stable(r_obuf[0])))
        else $error("digest word changed while stalled");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for sm3_hash_engine: message words in, digest words checked out.
module testbench;

    localparam int CYCLE_LIMIT = 600_000;
    localparam int ITEM_TARGET = 460;
    localparam int SETTLE_CYCLES = 200;   // a two-block pad plus digest drain fits easily

    localparam logic [31:0] SM3_IV [8] = '{
        32'h7380_166F, 32'h4914_B2B9, 32'h1724_42D7, 32'hDA8A_0600,
        32'hA96F_30BC, 32'h1631_38AA, 32'hE38D_EE4D, 32'hB0FB_0E4E
    };
    localparam logic [31:0] ROUND_K_EARLY = 32'h79CC_4519;
    localparam logic [31:0] ROUND_K_LATE  = 32'h7A87_9D8A;
    localparam logic [31:0] PAD_WORD      = 32'h8000_0000;
    localparam logic [2:0]  FULL_WORD     = 3'd4;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
        bit          drain_first;   // hold this word back until every digest is out
    } t_msg_word;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  pos;
        logic        tail;
    } t_digest_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sm3_in_if  msg_if ();
    sm3_out_if dig_if ();

    sm3_hash_engine dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_msg    (msg_if.sink),
        .o_digest (dig_if.source)
    );

    always #6 i_clk = ~i_clk;

    // ---------------- predictor state ----------------
    logic [31:0]  chain [8];
    logic [31:0]  blk [16];
    int unsigned  fill;
    logic [63:0]  bit_len;

    t_msg_word    message_words[$];
    t_digest_word expected_digest[$];
    int           fails = 0;
    int           words_total;
    int           words_taken = 0;
    int           cycles = 0;

    function automatic logic [31:0] rol32(logic [31:0] x, int n);
        int s;
        s = n % 32;
        if (s == 0)
            return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [31:0] perm_round(logic [31:0] x);
        return x ^ rol32(x, 9) ^ rol32(x, 17);
    endfunction

    function automatic logic [31:0] perm_expand(logic [31:0] x);
        return x ^ rol32(x, 15) ^ rol32(x, 23);
    endfunction

    function automatic void sm3_compress();
        logic [31:0] w [68];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] a12, ss1, ss2, tt1, tt2, fv, gv, tj;
        for (int j = 0; j < 16; j++)
            w[j] = blk[j];
        for (int j = 16; j < 68; j++)
            w[j] = perm_expand(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15))
                 ^ rol32(w[j-13], 7) ^ w[j-6];
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int j = 0; j < 64; j++) begin
            tj  = (j < 16) ? ROUND_K_EARLY : ROUND_K_LATE;
            a12 = rol32(a, 12);
            ss1 = rol32(a12 + e + rol32(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                fv = a ^ b ^ c;
                gv = e ^ f ^ g;
            end else begin
                fv = (a & b) | (a & c) | (b & c);
                gv = (e & f) | (~e & g);
            end
            tt1 = fv + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gv + h + ss1 + w[j];
            d = c; c = rol32(b, 9); b = a; a = tt1;
            h = g; g = rol32(f, 19); f = e; e = perm_round(tt2);
        end
        chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
        chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
    endfunction

    function automatic void absorb_word(logic [31:0] word);
        blk[fill] = word;
        fill = (fill + 1) % 16;
        if (fill == 0)
            sm3_compress();
    endfunction

    function automatic void restart_message();
        for (int k = 0; k < 8; k++)
            chain[k] = SM3_IV[k];
        fill    = 0;
        bit_len = '0;
    endfunction

    // Works out what one accepted message word does; a last word queues the digest.
    function automatic void hash_message_word(t_msg_word item);
        int          n;
        logic [31:0] keep;
        logic [31:0] pad;
        t_digest_word dw;
        if (!item.last) begin
            // partial counts are ignored away from the end of a message
            bit_len += 64'd32;
            absorb_word(item.word);
            return;
        end
        n = (item.nbytes > FULL_WORD) ? 4 : int'(item.nbytes);
        bit_len += 64'(8 * n);
        if (n == 4) begin
            absorb_word(item.word);
            absorb_word(PAD_WORD);
        end else begin
            keep = (n == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * n));
            pad  = 32'h80 << (24 - 8 * n);
            absorb_word((item.word & keep) | pad);
        end
        // no room left for the length: finish this block and pad a fresh one
        if (fill > 14)
            absorb_word(32'h0);
        while (fill < 14)
            absorb_word(32'h0);
        absorb_word(bit_len[63:32]);
        absorb_word(bit_len[31:0]);
        for (int k = 0; k < 8; k++) begin
            dw.word = chain[k];
            dw.pos  = 3'(k);
            dw.tail = (k == 7);
            expected_digest.push_back(dw);
        end
        restart_message();
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            fails++;
        end
    endfunction

    // ---------------- stimulus building ----------------
    task automatic push_word(logic [31:0] word, logic [2:0] nbytes, logic last, bit drain);
        t_msg_word m;
        m.word        = word;
        m.nbytes      = nbytes;
        m.last        = last;
        m.drain_first = drain;
        message_words.push_back(m);
    endtask

    // len words of random content; the odd inner word carries a junk byte count
    task automatic push_message(int len, logic [2:0] tail_bytes, bit drain);
        logic [2:0] nb;
        for (int i = 0; i < len - 1; i++) begin
            nb = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : FULL_WORD;
            push_word($urandom, nb, 1'b0, drain && i == 0);
        end
        push_word($urandom, tail_bytes, 1'b1, drain && len == 1);
    endtask

    // ---------------- driver ----------------
    t_msg_word cur_word;
    int        burst_left;
    int        gap_left;

    always @(posedge i_clk) begin : drive_words
        logic      fire;
        t_msg_word nxt;
        if (!i_rst_n) begin
            msg_if.valid      <= 1'b0;
            msg_if.msg_word   <= '0;
            msg_if.word_bytes <= '0;
            msg_if.last_word  <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
            restart_message();
        end else begin
            fire = msg_if.valid && msg_if.ready;
            if (fire) begin
                hash_message_word(cur_word);
                words_taken++;
            end
            if (msg_if.valid && !fire) begin
                // word still on offer: hold it
            end else if (gap_left > 0) begin
                gap_left--;
                msg_if.valid <= 1'b0;
            end else if (message_words.size() != 0 &&
                         !(message_words[0].drain_first && expected_digest.size() != 0)) begin
                nxt = message_words.pop_front();
                cur_word = nxt;
                msg_if.valid      <= 1'b1;
                msg_if.msg_word   <= nxt.word;
                msg_if.word_bytes <= nxt.nbytes;
                msg_if.last_word  <= nxt.last;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
            end else begin
                msg_if.valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver stalls ----------------
    logic [15:0] ready_pattern;
    int          pattern_age;

    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            dig_if.ready <= 1'b0;
            ready_pattern = 16'hFFFF;
            pattern_age   = 0;
        end else begin
            if (pattern_age == 0) begin
                pattern_age = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: ready_pattern = 16'hFFFF;
                    1: ready_pattern = 16'($urandom);
                    2: ready_pattern = 16'h0101;
                    default: ready_pattern = 16'h0001;
                endcase
            end
            pattern_age--;
            ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
            dig_if.ready <= ready_pattern[15];
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin : watch_digest
        t_digest_word want;
        if (i_rst_n && dig_if.valid && dig_if.ready) begin
            if (expected_digest.size() == 0) begin
                $error("unexpected digest word %h at index %0d",
                       dig_if.digest_word, dig_if.digest_index);
                fails++;
            end else begin
                want = expected_digest.pop_front();
                check_field("digest_word", want.word, dig_if.digest_word);
                check_field("digest_index", 32'(want.pos), 32'(dig_if.digest_index));
                check_field("digest_last", 32'(want.tail), 32'(dig_if.digest_last));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sm3_hash_engine test failed");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial begin : run
        int len;
        bit first_random;
        i_rst_n = 1'b0;

        // directed: empty message, stray bytes masked off
        push_word(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0);
        // the classic three-byte message
        push_word(32'h6162_6300, 3'd3, 1'b1, 1'b0);
        push_word(32'hFFFF_FFFF, 3'd1, 1'b1, 1'b0);
        push_word(32'h0000_0000, 3'd2, 1'b1, 1'b0);
        push_word(32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0);
        // byte counts above four behave as a full word
        push_word(32'h0123_4567, 3'd5, 1'b1, 1'b0);
        push_word(32'h89AB_CDEF, 3'd6, 1'b1, 1'b0);
        push_word(32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0);
        // fifteen-word message: the padded last word takes the length slot, so the
        // length moves to a second block; partial counts inside the message are ignored
        push_word(32'h0000_0000, 3'd0, 1'b0, 1'b0);
        push_word(32'hFFFF_FFFF, 3'd1, 1'b0, 1'b0);
        for (int i = 0; i < 12; i++)
            push_word($urandom, FULL_WORD, 1'b0, 1'b0);
        push_word(32'hA5A5_A5A5, 3'd2, 1'b1, 1'b0);

        // random messages, lengths clustered round the block boundary
        first_random = 1'b1;
        while (message_words.size() < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2: len = $urandom_range(1, 4);
                3, 4, 5: len = $urandom_range(13, 18);
                6, 7, 8: len = $urandom_range(1, 40);
                default: len = $urandom_range(41, 70);
            endcase
            push_message(len, 3'($urandom_range(0, 7)),
                         first_random || $urandom_range(0, 15) == 0);
            first_random = 1'b0;
        end
        words_total = message_words.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken < words_total || expected_digest.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fails == 0 && expected_digest.size() == 0)
            $display("sm3_hash_engine test passed");
        else
            $display("sm3_hash_engine test failed");
        $finish;
    end

endmodule

[sim.f]
hdl/sm3_pkg.sv
hdl/sm3_if.sv
hdl/sm3_ctrl.sv
hdl/sm3_dp.sv
hdl/sm3_hash_engine.sv
tb/sv/testbench.sv
